>>> rtl/aat_pkg.sv
// aat_pkg: shared types, constants and tables for accel_average_tilt.
// No dependencies.
package aat_pkg;

    localparam int MAX_SAMPLES_DEF  = 64;
    localparam int ADC_BITS_DEF     = 10;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_ADDR_W = 5;
    localparam int VOLT_W     = 16;
    localparam int ACC_W      = 19;
    localparam int ANG_W      = 16;
    localparam int CNT_W      = 7;

    // Register indexes
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_REF_MODE     = 3'd1;
    localparam logic [2:0] REG_ZERO_G_X     = 3'd2;
    localparam logic [2:0] REG_ZERO_G_Y     = 3'd3;
    localparam logic [2:0] REG_ZERO_G_Z     = 3'd4;
    localparam logic [2:0] REG_SENSITIVITY  = 3'd5;

    localparam logic [23:0] GRAV_NUM = 24'd980665;
    localparam int          ACC_MAX  = 262143;
    localparam int          ACC_MIN  = -262144;
    localparam logic signed [35:0] HALF_TURN = 36'sd1179648000; // 18000*65536

    typedef enum logic [3:0] {
        T_IDLE, T_VDIV, T_VWAIT, T_ADIV, T_AWAIT, T_CINIT, T_CSTEP, T_DONE, T_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       acc;      // accumulate the input transfer
        logic       div_start;
        logic       div_accel; // 0: voltage division, 1: accel division
        logic [1:0] axis;
        logic       cor_init;
        logic       cor_step;
        logic       finish;   // load result register, clear sums
    } t_cmd;

    typedef struct packed {
        logic set_full;
        logic div_done;
        logic cor_last;
    } t_sts;

    function automatic logic [31:0] vref_of(input logic [1:0] mode);
        case (mode)
            2'd2:    vref_of = 32'd11000;
            2'd3:    vref_of = 32'd25600;
            default: vref_of = 32'd50000;
        endcase
    endfunction

    function automatic logic signed [35:0] atan_of(input logic [4:0] i);
        case (i)
            5'd0:  atan_of = 36'sd294912000;
            5'd1:  atan_of = 36'sd174096719;
            5'd2:  atan_of = 36'sd91987925;
            5'd3:  atan_of = 36'sd46694507;
            5'd4:  atan_of = 36'sd23437865;
            5'd5:  atan_of = 36'sd11730358;
            5'd6:  atan_of = 36'sd5866610;
            5'd7:  atan_of = 36'sd2933485;
            5'd8:  atan_of = 36'sd1466764;
            5'd9:  atan_of = 36'sd733385;
            5'd10: atan_of = 36'sd366693;
            5'd11: atan_of = 36'sd183346;
            5'd12: atan_of = 36'sd91673;
            5'd13: atan_of = 36'sd45837;
            5'd14: atan_of = 36'sd22918;
            5'd15: atan_of = 36'sd11459;
            5'd16: atan_of = 36'sd5730;
            5'd17: atan_of = 36'sd2865;
            5'd18: atan_of = 36'sd1432;
            5'd19: atan_of = 36'sd716;
            5'd20: atan_of = 36'sd358;
            5'd21: atan_of = 36'sd179;
            5'd22: atan_of = 36'sd90;
            5'd23: atan_of = 36'sd45;
            default: atan_of = 36'sd0;
        endcase
    endfunction

endpackage

>>> rtl/accel_average_tilt_core.sv
// accel_average_tilt_core: per-axis sample averaging, acceleration and roll.
// Depends on aat_pkg, aat_ctrl, aat_dp, aat_div.
// Throughput: one input transfer per cycle until the set completes. The input then stalls
// until the result is taken. After the closing transfer the core runs six divisions (three voltage,
// then three acceleration), the CORDIC init and steps, and the result load before valid rises.
// Reset (synchronous, active low) clears sums, count, FSM, config to defaults.
module accel_average_tilt_core #(
    parameter int MAX_SAMPLES  = aat_pkg::MAX_SAMPLES_DEF,
    parameter int ADC_BITS     = aat_pkg::ADC_BITS_DEF,
    parameter int CORDIC_STEPS = aat_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [aat_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ADC_BITS-1:0]  i_sample_x,
    input  logic [ADC_BITS-1:0]  i_sample_y,
    input  logic [ADC_BITS-1:0]  i_sample_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_volt_x,
    output logic [15:0]          o_volt_y,
    output logic [15:0]          o_volt_z,
    output logic signed [18:0]   o_accel_x,
    output logic signed [18:0]   o_accel_y,
    output logic signed [18:0]   o_accel_z,
    output logic signed [15:0]   o_roll_angle
);
    logic [6:0]  r_sample_count;
    logic [1:0]  r_ref_mode;
    logic [15:0] r_zx, r_zy, r_zz, r_sens;
    logic [2:0]  w_idx;
    aat_pkg::t_cmd w_cmd;
    aat_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // config registers; writes land on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= 7'd1;
            r_ref_mode     <= 2'd0;
            r_zx           <= 16'd16500;
            r_zy           <= 16'd16500;
            r_zz           <= 16'd16500;
            r_sens         <= 16'd3300;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                aat_pkg::REG_SAMPLE_COUNT: r_sample_count <= pwdata[6:0];
                aat_pkg::REG_REF_MODE:     r_ref_mode     <= pwdata[1:0];
                aat_pkg::REG_ZERO_G_X:     r_zx           <= pwdata[15:0];
                aat_pkg::REG_ZERO_G_Y:     r_zy           <= pwdata[15:0];
                aat_pkg::REG_ZERO_G_Z:     r_zz           <= pwdata[15:0];
                aat_pkg::REG_SENSITIVITY:  r_sens         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            aat_pkg::REG_SAMPLE_COUNT: prdata = {25'd0, r_sample_count};
            aat_pkg::REG_REF_MODE:     prdata = {30'd0, r_ref_mode};
            aat_pkg::REG_ZERO_G_X:     prdata = {16'd0, r_zx};
            aat_pkg::REG_ZERO_G_Y:     prdata = {16'd0, r_zy};
            aat_pkg::REG_ZERO_G_Z:     prdata = {16'd0, r_zz};
            aat_pkg::REG_SENSITIVITY:  prdata = {16'd0, r_sens};
            default:                   prdata = '0;
        endcase
    end

    aat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aat_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .ADC_BITS    (ADC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sx          (i_sample_x),
        .i_sy          (i_sample_y),
        .i_sz          (i_sample_z),
        .i_sample_count(r_sample_count),
        .i_ref_mode    (r_ref_mode),
        .i_zx          (r_zx),
        .i_zy          (r_zy),
        .i_zz          (r_zz),
        .i_sens        (r_sens),
        .o_vx          (o_volt_x),
        .o_vy          (o_volt_y),
        .o_vz          (o_volt_z),
        .o_ax          (o_accel_x),
        .o_ay          (o_accel_y),
        .o_az          (o_accel_z),
        .o_roll        (o_roll_angle)
    );
endmodule

>>> rtl/aat_div.sv
// aat_div: restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its ports.
module aat_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem[31:0], r_quo[47]};
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd48;
            r_rem  <= '0;
            r_quo  <= i_num;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[46:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quo  = w_diff[32] ? {r_quo[46:0], 1'b0} : {r_quo[46:0], 1'b1};
endmodule

>>> rtl/aat_ctrl.sv
// aat_ctrl: sequencer for accumulate, six divisions and the CORDIC.
// Depends on aat_pkg.
module aat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  aat_pkg::t_sts i_sts,
    output aat_pkg::t_cmd o_cmd
);
    aat_pkg::t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aat_pkg::T_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            aat_pkg::T_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_sts.set_full) begin
                        n_state = aat_pkg::T_VDIV;
                        n_axis  = 2'd0;
                    end
                end
            end
            aat_pkg::T_VDIV: begin
                o_cmd.div_start = 1'b1;
                n_state = aat_pkg::T_VWAIT;
            end
            aat_pkg::T_VWAIT: if (i_sts.div_done) begin
                if (r_axis == 2'd2) begin
                    n_axis  = 2'd0;
                    n_state = aat_pkg::T_ADIV;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = aat_pkg::T_VDIV;
                end
            end
            aat_pkg::T_ADIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_accel = 1'b1;
                n_state = aat_pkg::T_AWAIT;
            end
            aat_pkg::T_AWAIT: begin
                o_cmd.div_accel = 1'b1;
                if (i_sts.div_done) begin
                    if (r_axis == 2'd2) begin
                        n_axis  = 2'd0;
                        n_state = aat_pkg::T_CINIT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = aat_pkg::T_ADIV;
                    end
                end
            end
            aat_pkg::T_CINIT: begin
                o_cmd.cor_init = 1'b1;
                n_state = aat_pkg::T_CSTEP;
            end
            aat_pkg::T_CSTEP: begin
                o_cmd.cor_step = 1'b1;
                if (i_sts.cor_last) n_state = aat_pkg::T_DONE;
            end
            aat_pkg::T_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = aat_pkg::T_OUT;
            end
            aat_pkg::T_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = aat_pkg::T_IDLE;
            end
            default: n_state = aat_pkg::T_IDLE;
        endcase
    end
endmodule

>>> rtl/aat_dp.sv
// aat_dp: sums, shared divider, saturation, CORDIC and result registers.
// Depends on aat_pkg and aat_div.
module aat_dp #(
    parameter int MAX_SAMPLES  = aat_pkg::MAX_SAMPLES_DEF,
    parameter int ADC_BITS     = aat_pkg::ADC_BITS_DEF,
    parameter int CORDIC_STEPS = aat_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aat_pkg::t_cmd              i_cmd,
    output aat_pkg::t_sts              o_sts,
    input  logic [ADC_BITS-1:0]        i_sx,
    input  logic [ADC_BITS-1:0]        i_sy,
    input  logic [ADC_BITS-1:0]        i_sz,
    input  logic [aat_pkg::CNT_W-1:0]  i_sample_count,
    input  logic [1:0]                 i_ref_mode,
    input  logic [15:0]                i_zx,
    input  logic [15:0]                i_zy,
    input  logic [15:0]                i_zz,
    input  logic [15:0]                i_sens,
    output logic [15:0]                o_vx,
    output logic [15:0]                o_vy,
    output logic [15:0]                o_vz,
    output logic signed [18:0]         o_ax,
    output logic signed [18:0]         o_ay,
    output logic signed [18:0]         o_az,
    output logic signed [15:0]         o_roll
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = ADC_BITS + CW;
    localparam int IW = $clog2(CORDIC_STEPS + 1);

    logic [SW-1:0] r_sum [3];
    logic [CW-1:0] r_taken;
    logic [15:0]   r_volt [3];
    logic signed [18:0] r_acc [3];
    logic signed [21:0] r_cx, r_cy;
    logic signed [35:0] r_cz;
    logic [IW-1:0] r_ci;
    logic [CW-1:0] w_n, w_next;
    logic [47:0] w_num, w_quo;
    logic [31:0] w_den;
    logic        w_done;
    logic signed [16:0] w_diff;
    logic [16:0] w_mag;
    logic [15:0] w_sens;
    logic [47:0] w_q;
    logic signed [21:0] w_sy, w_sx;
    logic signed [35:0] w_r;
    logic [15:0] w_bias;

    // effective count, clamped to 1..MAX_SAMPLES
    always_comb begin
        if (i_sample_count == '0) w_n = CW'(1);
        else if (32'(i_sample_count) > MAX_SAMPLES) w_n = CW'(MAX_SAMPLES);
        else w_n = CW'(i_sample_count);
    end
    assign w_next = r_taken + CW'(1);
    assign o_sts.set_full = (32'(w_next) >= 32'(w_n));

    always_comb begin
        case (i_cmd.axis)
            2'd1:    w_bias = i_zy;
            2'd2:    w_bias = i_zz;
            default: w_bias = i_zx;
        endcase
    end
    assign w_sens = (i_sens == '0) ? 16'd1 : i_sens;
    assign w_diff = $signed({1'b0, r_volt[i_cmd.axis]}) - $signed({1'b0, w_bias});
    assign w_mag  = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);

    always_comb begin
        logic [31:0] vden;
        logic [47:0] vnum;
        logic [31:0] aden;
        logic [47:0] anum;
        vden  = 32'(r_taken) << ADC_BITS;
        vnum  = 48'(aat_pkg::vref_of(i_ref_mode)) * 48'(r_sum[i_cmd.axis]);
        aden  = 32'(w_sens) * 32'd100;
        anum  = 48'(w_mag) * 48'(aat_pkg::GRAV_NUM);
        if (i_cmd.div_accel) begin
            w_num = anum + 48'(aden >> 1);
            w_den = aden;
        end else begin
            w_num = vnum + 48'(vden >> 1);
            w_den = vden;
        end
    end

    aat_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quo  (w_quo)
    );
    assign o_sts.div_done = w_done;
    assign w_q = w_diff[16] ? 48'(-w_quo) : w_quo;

    assign w_sy = r_cy >>> r_ci;
    assign w_sx = r_cx >>> r_ci;
    assign o_sts.cor_last = (32'(r_ci) == CORDIC_STEPS - 1);
    assign w_r  = (r_cz + 36'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end else if (i_cmd.acc) begin
            r_sum[0] <= r_sum[0] + SW'(i_sx);
            r_sum[1] <= r_sum[1] + SW'(i_sy);
            r_sum[2] <= r_sum[2] + SW'(i_sz);
            r_taken  <= w_next;
        end else if (i_cmd.finish) begin
            r_taken <= '0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && !i_cmd.div_accel) r_volt[i_cmd.axis] <= w_quo[15:0];
        if (w_done && i_cmd.div_accel) begin
            if (!w_diff[16] && w_quo > 48'(aat_pkg::ACC_MAX))
                r_acc[i_cmd.axis] <= 19'(aat_pkg::ACC_MAX);
            else if (w_diff[16] && w_quo > 48'(262144))
                r_acc[i_cmd.axis] <= 19'(aat_pkg::ACC_MIN);
            else
                r_acc[i_cmd.axis] <= w_q[18:0];
        end
        if (i_cmd.cor_init) begin
            r_ci <= '0;
            if (r_acc[2] < 0) begin
                r_cx <= -22'(r_acc[2]);
                r_cy <= -22'(r_acc[1]);
                r_cz <= (r_acc[1] >= 0) ? aat_pkg::HALF_TURN : -aat_pkg::HALF_TURN;
            end else begin
                r_cx <= 22'(r_acc[2]);
                r_cy <= 22'(r_acc[1]);
                r_cz <= '0;
            end
        end else if (i_cmd.cor_step) begin
            r_ci <= r_ci + IW'(1);
            if (r_cy >= 0) begin
                r_cx <= r_cx + w_sy;
                r_cy <= r_cy - w_sx;
                r_cz <= r_cz + aat_pkg::atan_of(5'(r_ci));
            end else begin
                r_cx <= r_cx - w_sy;
                r_cy <= r_cy + w_sx;
                r_cz <= r_cz - aat_pkg::atan_of(5'(r_ci));
            end
        end
        if (i_cmd.finish) begin
            o_vx <= r_volt[0];
            o_vy <= r_volt[1];
            o_vz <= r_volt[2];
            o_ax <= r_acc[0];
            o_ay <= r_acc[1];
            o_az <= r_acc[2];
            if (r_acc[1] == 0 && r_acc[2] == 0) o_roll <= '0;
            else if (w_r > 36'sd18000) o_roll <= 16'sd18000;
            else if (w_r < -36'sd18000) o_roll <= -16'sd18000;
            else o_roll <= w_r[15:0];
        end
    end
endmodule

>>> rtl/aat_checker.sv
// aat_checker: port-level properties of accel_average_tilt_core.
// Depends on the core's ports only; bound below.
module aat_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_roll_angle
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_roll_angle))
        else $error("result dropped or changed under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_roll_angle <= 16'sd18000 && o_roll_angle >= -16'sd18000))
        else $error("roll out of range");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("valid after reset");
endmodule

bind accel_average_tilt_core aat_checker u_aat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_roll_angle(o_roll_angle)
);
